@@ design/ifc_pkg.sv @@
// shared constants, widths and codes for the indexed frame compositor
package ifc_pkg;

  localparam int PALETTE_DEPTH  = 256;
  localparam int MAX_CANVAS_DIM = 1024;

  localparam int PAL_AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int MODE_W     = 2;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int IDX_W      = 8;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int ADDR_W     = 20;
  localparam int PSIZE_W    = 9;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEFT        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENCY_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE      = 3'd7;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

endpackage

@@ design/ifc_pixel_if.sv @@
// input channel: palette loads, draws and clears
interface ifc_pixel_if
  import ifc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] local_x;
  logic [COORD_W-1:0] local_y;
  logic [IDX_W-1:0]   color_index;
  logic [CH_W-1:0]    load_red;
  logic [CH_W-1:0]    load_green;
  logic [CH_W-1:0]    load_blue;

  modport source (
    output valid, mode, local_x, local_y, color_index, load_red, load_green, load_blue,
    input  ready
  );
  modport sink (
    input  valid, mode, local_x, local_y, color_index, load_red, load_green, load_blue,
    output ready
  );
endinterface

@@ design/ifc_canvas_if.sv @@
// output channel: canvas pixel writes
interface ifc_canvas_if
  import ifc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [ADDR_W-1:0] pixel_address;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic [CH_W-1:0]   out_alpha;

  modport source (
    output valid, write_enable, pixel_address, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_address, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

@@ design/ifc_ram.sv @@
// generic single-write, single-read ram with registered read data
module ifc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/indexed_frame_compositor.sv @@
// top level: palette-indexed pixel compositing onto an rgba canvas
//
//  channel  dir  handshake      payload
//  pixel    in   valid/ready    mode, local_x, local_y, color_index, load_red/green/blue
//  canvas   out  valid/ready    write_enable, pixel_address, out_red/green/blue/alpha
//  cfg      in   cfg_write      cfg_index, cfg_data
//
// one item per cycle unless the output stalls; the item is registered in the input stage, and the result
// in the output stage (palette ram read into the input stage, then placement, drop tests and address)
// synchronous reset empties both stages and loads the register defaults
// a stalled output holds stage 2, and stage 1 when it is full; ready drops only when both stages are full
module indexed_frame_compositor
  import ifc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ifc_pixel_if.sink             pixel,
  ifc_canvas_if.source          canvas
);

  // configuration
  logic [COORD_W-1:0] frame_left;
  logic [COORD_W-1:0] frame_top;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  logic               transparency_on;
  logic [IDX_W-1:0]   transparent_color;
  logic [PSIZE_W-1:0] palette_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_left        <= '0;
      frame_top         <= '0;
      frame_width       <= DIM_W'(1);
      screen_width      <= DIM_W'(1);
      screen_height     <= DIM_W'(1);
      transparency_on   <= 1'b0;
      transparent_color <= '0;
      palette_size      <= PSIZE_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_LEFT:        frame_left        <= cfg_data[COORD_W-1:0];
        REG_FRAME_TOP:         frame_top         <= cfg_data[COORD_W-1:0];
        REG_FRAME_WIDTH:       frame_width       <= cfg_data[DIM_W-1:0];
        REG_SCREEN_WIDTH:      screen_width      <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT:     screen_height     <= cfg_data[DIM_W-1:0];
        REG_TRANSPARENCY_ON:   transparency_on   <= cfg_data[0];
        REG_TRANSPARENT_COLOR: transparent_color <= cfg_data[IDX_W-1:0];
        REG_PALETTE_SIZE:      palette_size      <= cfg_data[PSIZE_W-1:0];
      endcase
    end
  end

  // stage enables
  logic en1, en2;
  logic v1, v2;
  logic accept;

  assign en2 = !v2 || canvas.ready;
  assign en1 = !v1 || en2;
  assign pixel.ready = en1;
  assign accept = pixel.valid && en1;

  // palette
  logic             pal_we;
  logic [RGB_W-1:0] pal_rdata;

  assign pal_we = accept && (pixel.mode == MODE_LOAD)
                  && (32'(pixel.color_index) < PALETTE_DEPTH);

  ifc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pixel.color_index[PAL_AW-1:0]),
    .wdata ({pixel.load_red, pixel.load_green, pixel.load_blue}),
    .re    (en1),
    .raddr (pixel.color_index[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  // stage 1: captured item
  logic [MODE_W-1:0]  mode1;
  logic [COORD_W-1:0] lx1;
  logic [COORD_W-1:0] ly1;
  logic [IDX_W-1:0]   idx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mode1 <= pixel.mode;
      lx1   <= pixel.local_x;
      ly1   <= pixel.local_y;
      idx1  <= pixel.color_index;
    end
  end

  // placement, drop tests and address
  logic [DIM_W-1:0]   cw;
  logic [DIM_W-1:0]   ch;
  logic [PSIZE_W-1:0] psize;
  logic [DIM_W-1:0]   x_next;
  logic [DIM_W-1:0]   y_next;
  logic               placed;
  logic               draw_ok;
  logic               clear_ok;
  logic               we_next;
  logic [PROD_W-1:0]  addr_next;

  always_comb begin
    cw = (32'(screen_width) > MAX_CANVAS_DIM) ? DIM_W'(MAX_CANVAS_DIM) : screen_width;
    ch = (32'(screen_height) > MAX_CANVAS_DIM) ? DIM_W'(MAX_CANVAS_DIM) : screen_height;
    psize = (32'(palette_size) > PALETTE_DEPTH) ? PSIZE_W'(PALETTE_DEPTH) : palette_size;
    x_next = DIM_W'(frame_left) + DIM_W'(lx1);
    y_next = DIM_W'(frame_top) + DIM_W'(ly1);
    placed = (DIM_W'(lx1) < frame_width) && (x_next < cw) && (y_next < ch);
    draw_ok = (mode1 == MODE_DRAW) && placed
              && !(transparency_on && (idx1 == transparent_color))
              && (PSIZE_W'(idx1) < psize);
    clear_ok = (mode1 == MODE_CLEAR) && placed;
    we_next = draw_ok || clear_ok;
    addr_next = PROD_W'(y_next) * PROD_W'(cw) + PROD_W'(x_next);
  end

  // stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      canvas.write_enable  <= we_next;
      canvas.pixel_address <= we_next ? addr_next[ADDR_W-1:0] : '0;
      canvas.out_red       <= draw_ok ? pal_rdata[RGB_W-1 -: CH_W] : '0;
      canvas.out_green     <= draw_ok ? pal_rdata[2*CH_W-1 -: CH_W] : '0;
      canvas.out_blue      <= draw_ok ? pal_rdata[CH_W-1:0] : '0;
      canvas.out_alpha     <= we_next ? ALPHA_OPAQUE : '0;
    end
  end

  assign canvas.valid = v2;

endmodule

@@ design/ifc_checker.sv @@
// port-level checks for the compositor, bound to the top level
module ifc_checker
  import ifc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              pixel_valid,
  input logic              pixel_ready,
  input logic              canvas_valid,
  input logic              canvas_ready,
  input logic              write_enable,
  input logic [ADDR_W-1:0] pixel_address,
  input logic [CH_W-1:0]   out_red,
  input logic [CH_W-1:0]   out_green,
  input logic [CH_W-1:0]   out_blue,
  input logic [CH_W-1:0]   out_alpha
);

  logic [1:0] inflight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = pixel_valid && pixel_ready;
  assign out_acc = canvas_valid && canvas_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    canvas_valid && !write_enable |->
      pixel_address == '0 && out_red == '0 && out_green == '0 && out_blue == '0
      && out_alpha == '0)
    else $error("item without write carries nonzero fields");

  a_write_opaque: assert property (@(posedge clk) disable iff (rst)
    canvas_valid && write_enable |-> out_alpha == ALPHA_OPAQUE)
    else $error("canvas write is not opaque");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    (in_acc |-> inflight != 2'd2 || out_acc) and (canvas_valid |-> inflight != 2'd0))
    else $error("items in flight out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    canvas_valid && !canvas_ready |=> canvas_valid && $stable(pixel_address)
      && $stable(write_enable) && $stable(out_red))
    else $error("stalled result changed");

endmodule

bind indexed_frame_compositor ifc_checker u_ifc_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_valid   (pixel.valid),
  .pixel_ready   (pixel.ready),
  .canvas_valid  (canvas.valid),
  .canvas_ready  (canvas.ready),
  .write_enable  (canvas.write_enable),
  .pixel_address (canvas.pixel_address),
  .out_red       (canvas.out_red),
  .out_green     (canvas.out_green),
  .out_blue      (canvas.out_blue),
  .out_alpha     (canvas.out_alpha)
);

@@ tb/indexed_frame_compositor_tb.sv @@
`timescale 1ns / 100ps
// testbench for indexed_frame_compositor: directed and random items against a compositing model
module indexed_frame_compositor_tb;
  import ifc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_REGS      = 8;
  localparam int MAX_GAP       = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] local_x;
    logic [COORD_W-1:0] local_y;
    logic [IDX_W-1:0]   color_index;
    logic [CH_W-1:0]    load_red;
    logic [CH_W-1:0]    load_green;
    logic [CH_W-1:0]    load_blue;
  } pixel_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
  } canvas_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ifc_pixel_if  pix ();
  ifc_canvas_if canv ();

  indexed_frame_compositor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix),
    .canvas    (canv)
  );

  logic [CFG_DATA_W-1:0] reg_value [NUM_REGS];
  logic [RGB_W-1:0]      palette_model [PALETTE_DEPTH];
  bit                    palette_loaded [PALETTE_DEPTH];
  int                    loaded_list [$];
  pixel_item_t           pixel_queue [$];
  canvas_item_t          pending_writes [$];
  bit                    send_idle_on = 1'b0;
  bit                    recv_idle_on = 1'b0;
  int                    send_gap = 0;
  int                    recv_stall = 0;
  int                    mismatches = 0;
  int                    idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic canvas_item_t composite_pixel(pixel_item_t p);
    canvas_item_t res;
    int cw, ch, col, row, psize;
    bit on_canvas;
    res = '0;
    cw = reg_value[REG_SCREEN_WIDTH];
    if (cw > MAX_CANVAS_DIM) cw = MAX_CANVAS_DIM;
    ch = reg_value[REG_SCREEN_HEIGHT];
    if (ch > MAX_CANVAS_DIM) ch = MAX_CANVAS_DIM;
    psize = reg_value[REG_PALETTE_SIZE];
    if (psize > PALETTE_DEPTH) psize = PALETTE_DEPTH;
    col = reg_value[REG_FRAME_LEFT] + p.local_x;
    row = reg_value[REG_FRAME_TOP] + p.local_y;
    on_canvas = (p.local_x < reg_value[REG_FRAME_WIDTH]) && (col < cw) && (row < ch);
    case (p.mode)
      MODE_LOAD: palette_model[p.color_index] = {p.load_red, p.load_green, p.load_blue};
      MODE_DRAW: begin
        if (on_canvas && !(reg_value[REG_TRANSPARENCY_ON][0] &&
                           p.color_index == reg_value[REG_TRANSPARENT_COLOR]) &&
            p.color_index < psize) begin
          res.write_enable = 1'b1;
          res.pixel_address = ADDR_W'(row * cw + col);
          {res.red, res.green, res.blue} = palette_model[p.color_index];
          res.alpha = ALPHA_OPAQUE;
        end
      end
      MODE_CLEAR: begin
        if (on_canvas) begin
          res.write_enable = 1'b1;
          res.pixel_address = ADDR_W'(row * cw + col);
          res.alpha = ALPHA_OPAQUE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic pixel_item_t make_item(logic [MODE_W-1:0] mode, int x, int y, int idx,
                                            int r, int g, int b);
    pixel_item_t it;
    it.mode = mode;
    it.local_x = COORD_W'(x);
    it.local_y = COORD_W'(y);
    it.color_index = IDX_W'(idx);
    it.load_red = CH_W'(r);
    it.load_green = CH_W'(g);
    it.load_blue = CH_W'(b);
    return it;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(3, 0))
      0: return $urandom_range(16, 1);
      1: return $urandom_range(128, 1);
      2: return $urandom_range(1024, 1);
      default: return ($urandom_range(1, 0) != 0) ? MAX_CANVAS_DIM : 1;
    endcase
  endfunction

  function automatic pixel_item_t random_item();
    pixel_item_t it;
    int roll, span_x, span_y;
    it.local_x = COORD_W'($urandom());
    it.local_y = COORD_W'($urandom());
    it.color_index = IDX_W'($urandom());
    it.load_red = CH_W'($urandom());
    it.load_green = CH_W'($urandom());
    it.load_blue = CH_W'($urandom());
    roll = $urandom_range(99, 0);
    if (roll < 25 || loaded_list.size() == 0) it.mode = MODE_LOAD;
    else if (roll < 80) it.mode = MODE_DRAW;
    else if (roll < 95) it.mode = MODE_CLEAR;
    else it.mode = MODE_UNUSED;
    // draws only use loaded palette entries
    if (it.mode == MODE_DRAW) begin
      if (reg_value[REG_TRANSPARENCY_ON][0] && palette_loaded[reg_value[REG_TRANSPARENT_COLOR]] &&
          $urandom_range(5, 0) == 0)
        it.color_index = IDX_W'(reg_value[REG_TRANSPARENT_COLOR]);
      else if (!palette_loaded[it.color_index])
        it.color_index = IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1, 0)]);
    end
    // most draws and clears land inside the visible part of the frame
    span_x = reg_value[REG_FRAME_WIDTH];
    if (int'(reg_value[REG_SCREEN_WIDTH]) - int'(reg_value[REG_FRAME_LEFT]) < span_x)
      span_x = int'(reg_value[REG_SCREEN_WIDTH]) - int'(reg_value[REG_FRAME_LEFT]);
    span_y = int'(reg_value[REG_SCREEN_HEIGHT]) - int'(reg_value[REG_FRAME_TOP]);
    if ((it.mode == MODE_DRAW || it.mode == MODE_CLEAR) && $urandom_range(3, 0) != 0) begin
      if (span_x > 0) it.local_x = COORD_W'($urandom_range(span_x - 1, 0));
      if (span_y > 0) it.local_y = COORD_W'($urandom_range(span_y - 1, 0));
    end
    return it;
  endfunction

  task automatic queue_item(pixel_item_t it);
    if (it.mode == MODE_LOAD && !palette_loaded[it.color_index]) begin
      palette_loaded[it.color_index] = 1'b1;
      loaded_list.push_back(it.color_index);
    end
    pixel_queue.push_back(it);
  endtask

  task automatic wait_quiet();
    while (pixel_queue.size() != 0 || pix.valid || pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(int left, int top, int fwidth, int cwidth, int cheight,
                               int t_on, int t_color, int psize);
    reg_value[REG_FRAME_LEFT] = CFG_DATA_W'(left);
    reg_value[REG_FRAME_TOP] = CFG_DATA_W'(top);
    reg_value[REG_FRAME_WIDTH] = CFG_DATA_W'(fwidth);
    reg_value[REG_SCREEN_WIDTH] = CFG_DATA_W'(cwidth);
    reg_value[REG_SCREEN_HEIGHT] = CFG_DATA_W'(cheight);
    reg_value[REG_TRANSPARENCY_ON] = CFG_DATA_W'(t_on);
    reg_value[REG_TRANSPARENT_COLOR] = CFG_DATA_W'(t_color);
    reg_value[REG_PALETTE_SIZE] = CFG_DATA_W'(psize);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= reg_value[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // pixel item driver
  always @(posedge clk) begin
    pixel_item_t it;
    if (rst) begin
      pix.valid <= 1'b0;
      send_gap <= 0;
    end else if (!pix.valid || pix.ready) begin
      if (send_gap != 0) begin
        pix.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        it = pixel_queue.pop_front();
        pix.valid <= 1'b1;
        pix.mode <= it.mode;
        pix.local_x <= it.local_x;
        pix.local_y <= it.local_y;
        pix.color_index <= it.color_index;
        pix.load_red <= it.load_red;
        pix.load_green <= it.load_green;
        pix.load_blue <= it.load_blue;
        send_gap <= send_idle_on ? $urandom_range(MAX_GAP, 0) : 0;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // canvas receiver with random stalls
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      canv.ready <= 1'b0;
      recv_stall <= 0;
    end else if (canv.valid && canv.ready) begin
      stall = recv_idle_on ? $urandom_range(MAX_GAP, 0) : 0;
      recv_stall <= stall;
      canv.ready <= (stall == 0);
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      canv.ready <= (recv_stall == 1);
    end else begin
      canv.ready <= !(recv_idle_on && $urandom_range(3, 0) == 0);
    end
  end

  // prediction on accepted pixel items, check on accepted canvas items
  always @(posedge clk) begin
    pixel_item_t arrived;
    canvas_item_t got, want;
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        arrived = {pix.mode, pix.local_x, pix.local_y, pix.color_index,
                   pix.load_red, pix.load_green, pix.load_blue};
        pending_writes.push_back(composite_pixel(arrived));
      end
      if (canv.valid && canv.ready) begin
        got = {canv.write_enable, canv.pixel_address, canv.out_red, canv.out_green,
               canv.out_blue, canv.out_alpha};
        if (pending_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected canvas item: we=%0d addr=%0d rgba=%h", got.write_enable,
                     got.pixel_address, {got.red, got.green, got.blue, got.alpha});
        end else begin
          want = pending_writes.pop_front();
          if (got.write_enable !== want.write_enable || got.pixel_address !== want.pixel_address ||
              got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.alpha !== want.alpha) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"canvas mismatch: expected we=%0d addr=%0d rgba=%h, ",
                        "got we=%0d addr=%0d rgba=%h"},
                       want.write_enable, want.pixel_address,
                       {want.red, want.green, want.blue, want.alpha},
                       got.write_enable, got.pixel_address,
                       {got.red, got.green, got.blue, got.alpha});
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (canv.valid && canv.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int cw, ch;
    pix.valid = 1'b0;
    pix.mode = MODE_LOAD;
    pix.local_x = '0;
    pix.local_y = '0;
    pix.color_index = '0;
    pix.load_red = '0;
    pix.load_green = '0;
    pix.load_blue = '0;
    canv.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full canvas, transparency on the top index
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    set_registers(0, 0, 1024, 1024, 1024, 1, 255, 256);
    queue_item(make_item(MODE_LOAD, 0, 0, 0, 255, 255, 255));
    queue_item(make_item(MODE_LOAD, 1023, 1023, 255, 0, 0, 0));
    queue_item(make_item(MODE_LOAD, 0, 0, 1, 255, 0, 128));
    queue_item(make_item(MODE_LOAD, 0, 0, 128, 1, 254, 127));
    queue_item(make_item(MODE_DRAW, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 1023, 1023, 1, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 1023, 0, 128, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 0, 1023, 255, 0, 0, 0));
    queue_item(make_item(MODE_CLEAR, 1023, 1023, 0, 0, 0, 0));
    queue_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(MODE_UNUSED, 5, 5, 1, 255, 255, 255));
    wait_quiet();

    // one-pixel frame at the far corner, half palette
    set_registers(1023, 1023, 1, 1024, 1024, 0, 255, 128);
    queue_item(make_item(MODE_DRAW, 0, 0, 255, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 0, 0, 128, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 0, 0, 1, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 1, 0, 1, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 0, 1, 1, 0, 0, 0));
    queue_item(make_item(MODE_CLEAR, 0, 1, 0, 0, 0, 0));
    queue_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
    wait_quiet();

    // one-pixel canvas, index zero transparent
    set_registers(0, 0, 1, 1, 1, 1, 0, 256);
    queue_item(make_item(MODE_DRAW, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 0, 0, 1, 0, 0, 0));
    queue_item(make_item(MODE_DRAW, 1, 0, 1, 0, 0, 0));
    queue_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_quiet();
      send_idle_on = (p % 4) < 2;
      recv_idle_on = (p % 4 == 0) || (p % 4 == 3);
      if (p == 1) begin
        set_registers(1023, 1023, 1024, 1024, 1024, 1, 255, 256);
      end else if (p == 4) begin
        set_registers(0, 0, 1, 1, 1, 0, 0, 0);
      end else if (p == 6) begin
        set_registers(0, 0, 1024, 1024, 1024, 0, 0, 256);
      end else begin
        cw = pick_dim();
        ch = pick_dim();
        set_registers(($urandom_range(4, 0) != 0) ? $urandom_range(cw - 1, 0) :
                        $urandom_range(1023, 0),
                      ($urandom_range(4, 0) != 0) ? $urandom_range(ch - 1, 0) :
                        $urandom_range(1023, 0),
                      pick_dim(), cw, ch, $urandom_range(1, 0),
                      ($urandom_range(3, 0) != 0) ?
                        loaded_list[$urandom_range(loaded_list.size() - 1, 0)] :
                        $urandom_range(255, 0),
                      ($urandom_range(4, 0) < 3) ? PALETTE_DEPTH :
                        $urandom_range(PALETTE_DEPTH, 0));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) queue_item(random_item());
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
